// File: src/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package qrm_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int NUM_ENT    = 9;
  localparam int PROD_W     = 2 * COMP_WIDTH;
  localparam int DEN_W      = 2 * COMP_WIDTH + 1;
  localparam int REM_W      = 2 * COMP_WIDTH + 2;
  localparam int NUM_W      = 2 * COMP_WIDTH + 3;
  localparam int QUO_W      = FRAC_BITS + 1;

  localparam logic [QUO_W-1:0] ONE_FIX = QUO_W'(1) << FRAC_BITS;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  typedef struct packed {
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
  } quat_t;

  typedef struct packed {
    comp_t r00;
    comp_t r01;
    comp_t r02;
    comp_t r10;
    comp_t r11;
    comp_t r12;
    comp_t r20;
    comp_t r21;
    comp_t r22;
    logic  zero_norm;
  } rot_t;

  // One matrix entry in flight through the divider
  typedef struct packed {
    logic                 neg;
    logic                 sat;
    logic [REM_W-1:0]     rem;
    logic [FRAC_BITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                   zero;
    logic [DEN_W-1:0]       den;
    lane_t [NUM_ENT-1:0]    lane;
  } div_item_t;

endpackage
`default_nettype wire

// File: src/qrm_front.sv
// Front end: products, norm and numerators, then sign/magnitude split.
// Three register stages; depends on qrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrm_front import qrm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire logic      valid_i,
  input  wire quat_t     data_i,
  output logic           valid_o,
  output div_item_t      item_o
);

  logic signed [PROD_W-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;
  logic signed [NUM_W-1:0]  num_d [NUM_ENT];
  logic signed [NUM_W-1:0]  num_q [NUM_ENT];
  logic [DEN_W-1:0]         den_d, den_q;
  logic                     va_q, vb_q, vc_q;
  div_item_t                item_d, item_q;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Stage A: all ten products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ww_q <= data_i.quat_w * data_i.quat_w;
      xx_q <= data_i.quat_x * data_i.quat_x;
      yy_q <= data_i.quat_y * data_i.quat_y;
      zz_q <= data_i.quat_z * data_i.quat_z;
      xy_q <= data_i.quat_x * data_i.quat_y;
      zw_q <= data_i.quat_z * data_i.quat_w;
      xz_q <= data_i.quat_x * data_i.quat_z;
      yw_q <= data_i.quat_y * data_i.quat_w;
      yz_q <= data_i.quat_y * data_i.quat_z;
      xw_q <= data_i.quat_x * data_i.quat_w;
    end
  end

  // Stage B: norm and the nine signed numerators
  always_comb begin
    den_d = {1'b0, ww_q} + {1'b0, xx_q} + {1'b0, yy_q} + {1'b0, zz_q};
    num_d[0] = NUM_W'(ww_q) + NUM_W'(xx_q) - NUM_W'(yy_q) - NUM_W'(zz_q);
    num_d[1] = (NUM_W'(xy_q) - NUM_W'(zw_q)) <<< 1;
    num_d[2] = (NUM_W'(xz_q) + NUM_W'(yw_q)) <<< 1;
    num_d[3] = (NUM_W'(xy_q) + NUM_W'(zw_q)) <<< 1;
    num_d[4] = NUM_W'(ww_q) - NUM_W'(xx_q) + NUM_W'(yy_q) - NUM_W'(zz_q);
    num_d[5] = (NUM_W'(yz_q) - NUM_W'(xw_q)) <<< 1;
    num_d[6] = (NUM_W'(xz_q) - NUM_W'(yw_q)) <<< 1;
    num_d[7] = (NUM_W'(yz_q) + NUM_W'(xw_q)) <<< 1;
    num_d[8] = NUM_W'(ww_q) - NUM_W'(xx_q) - NUM_W'(yy_q) + NUM_W'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q <= den_d;
      num_q <= num_d;
    end
  end

  // Stage C: split sign and magnitude, flag ratios at or above one
  always_comb begin
    logic [NUM_W-1:0] mag;
    item_d.zero = (den_q == '0);
    item_d.den  = den_q;
    for (int i = 0; i < NUM_ENT; i++) begin
      mag = num_q[i][NUM_W-1] ? NUM_W'(-num_q[i]) : NUM_W'(num_q[i]);
      item_d.lane[i].neg = num_q[i][NUM_W-1];
      item_d.lane[i].rem = mag[REM_W-1:0];
      item_d.lane[i].sat = (mag[REM_W-1:0] >= {1'b0, den_q});
      item_d.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = vc_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// File: src/qrm_div_step.sv
// One restoring division step for all nine entries: one quotient bit each.
// Depends on qrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrm_div_step import qrm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire logic      valid_i,
  input  wire div_item_t item_i,
  output logic           valid_o,
  output div_item_t      item_o
);

  div_item_t item_d, item_q;
  logic      valid_q;

  // Shift, trial subtract, take the quotient bit
  always_comb begin
    logic [REM_W-1:0] r2;
    logic             ge;
    item_d = item_i;
    for (int i = 0; i < NUM_ENT; i++) begin
      r2 = {item_i.lane[i].rem[REM_W-2:0], 1'b0};
      ge = (r2 >= {1'b0, item_i.den});
      item_d.lane[i].rem = ge ? (r2 - {1'b0, item_i.den}) : r2;
      item_d.lane[i].quo = {item_i.lane[i].quo[FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// File: src/quat_to_rotation_matrix.sv
// Top level: quaternion in, 3x3 rotation matrix out, fully pipelined.
// Depends on qrm_pkg, qrm_front and qrm_div_step.
//
// Usage:
//   Input channel in_valid_i / in_ready_o / in_data_i carries one quaternion
//   (w, x, y, z), signed Q2.14. Output channel out_valid_o / out_ready_i /
//   out_data_o carries the nine matrix entries in signed Q2.14, rounded to
//   nearest and limited to +-1.0, plus zero_norm. An all-zero quaternion
//   returns the identity with zero_norm set.
//   The pipeline has three front stages (products, sums, magnitude split),
//   one stage per quotient bit of the restoring divider, and the rounding/output
//   register. One transaction is taken every cycle unless the output stalls.
//   The whole pipeline advances together; when the receiver holds
//   out_ready_i low while a result waits, every stage holds and in_ready_o
//   drops, so nothing is lost or repeated. Reset clears all valid bits; the
//   block holds no other state.
`timescale 1ns / 1ps
`default_nettype none
module quat_to_rotation_matrix import qrm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire quat_t in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output rot_t       out_data_o
);

  logic      adv;
  logic      v_pipe [FRAC_BITS+1];
  div_item_t d_pipe [FRAC_BITS+1];
  logic      out_valid_q;
  rot_t      out_d, out_q;

  // Advance everything unless a finished result is stuck
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  qrm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v_pipe[0]),
    .item_o  (d_pipe[0])
  );

  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_div
    qrm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (v_pipe[s]),
      .item_i  (d_pipe[s]),
      .valid_o (v_pipe[s+1]),
      .item_o  (d_pipe[s+1])
    );
  end

  // Round, cap and apply the sign; substitute identity for a zero norm
  always_comb begin
    logic [QUO_W-1:0] q;
    comp_t            ent [NUM_ENT];
    div_item_t        it;
    it = d_pipe[FRAC_BITS];
    for (int i = 0; i < NUM_ENT; i++) begin
      q = {1'b0, it.lane[i].quo}
        + QUO_W'({it.lane[i].rem, 1'b0} >= {2'b00, it.den});
      if (it.lane[i].sat || q > ONE_FIX) begin
        q = ONE_FIX;
      end
      ent[i] = comp_t'(q);
      if (it.lane[i].neg) begin
        ent[i] = -ent[i];
      end
    end
    if (it.zero) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        ent[i] = (i % 4 == 0) ? comp_t'(ONE_FIX) : '0;
      end
    end
    out_d.r00       = ent[0];
    out_d.r01       = ent[1];
    out_d.r02       = ent[2];
    out_d.r10       = ent[3];
    out_d.r11       = ent[4];
    out_d.r12       = ent[5];
    out_d.r20       = ent[6];
    out_d.r21       = ent[7];
    out_d.r22       = ent[8];
    out_d.zero_norm = it.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_pipe[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Testbench for quat_to_rotation_matrix: fixed-point quaternion to rotation matrix.
// Depends on qrm_pkg; predicts every matrix with its own integer arithmetic.
`timescale 1ns / 1ps
module tb_top;
  import qrm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  quat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rot_t out_data_o;

  rot_t matrix_q[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;
  bit pressure_req = 1'b0;
  int stall_left = 0;

  quat_to_rotation_matrix u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Round |num| * 2^FRAC_BITS / den to nearest, cap at 1.0, apply sign
  function automatic comp_t matrix_entry(longint num, longint den);
    longint mag, quo, rem;
    mag = (num < 0) ? -num : num;
    if (mag >= den) begin
      quo = longint'(1) << FRAC_BITS;
    end else begin
      quo = (mag << FRAC_BITS) / den;
      rem = (mag << FRAC_BITS) % den;
      if (2 * rem >= den) quo++;
      if (quo > (longint'(1) << FRAC_BITS)) quo = longint'(1) << FRAC_BITS;
    end
    return (num < 0) ? comp_t'(-quo) : comp_t'(quo);
  endfunction

  function automatic rot_t rotation_of(quat_t q);
    rot_t m;
    longint w, x, y, z, n;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    n = w*w + x*x + y*y + z*z;
    m = '0;
    if (n == 0) begin
      m.r00 = comp_t'(1 << FRAC_BITS);
      m.r11 = comp_t'(1 << FRAC_BITS);
      m.r22 = comp_t'(1 << FRAC_BITS);
      m.zero_norm = 1'b1;
      return m;
    end
    m.r00 = matrix_entry(w*w + x*x - y*y - z*z, n);
    m.r01 = matrix_entry(2 * (x*y - z*w), n);
    m.r02 = matrix_entry(2 * (x*z + y*w), n);
    m.r10 = matrix_entry(2 * (x*y + z*w), n);
    m.r11 = matrix_entry(w*w - x*x + y*y - z*z, n);
    m.r12 = matrix_entry(2 * (y*z - x*w), n);
    m.r20 = matrix_entry(2 * (x*z - y*w), n);
    m.r21 = matrix_entry(2 * (y*z + x*w), n);
    m.r22 = matrix_entry(w*w - x*x - y*y + z*z, n);
    return m;
  endfunction

  // Offer one quaternion, optionally after a random gap, and log its matrix
  task automatic send_quat(quat_t q);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    matrix_q.push_back(rotation_of(q));
  endtask

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.quat_w = comp_t'(w); q.quat_x = comp_t'(x);
    q.quat_y = comp_t'(y); q.quat_z = comp_t'(z);
    return q;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 15)) - comp_t'(8);
      1: return comp_t'($urandom_range(0, 2047)) - comp_t'(1024);
      2: return $urandom_range(0, 1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
      3: return comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Extremes, pure axes, zero quaternion and tiny norms
  task automatic test_directed();
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(16384, 0, 0, 0));
    send_quat(make_quat(0, 16384, 0, 0));
    send_quat(make_quat(0, 0, 16384, 0));
    send_quat(make_quat(0, 0, 0, 16384));
    send_quat(make_quat(-16384, 0, 0, 0));
    send_quat(make_quat(0, 0, 0, -1));
    send_quat(make_quat(1, 0, 0, 0));
    send_quat(make_quat(1, 1, 1, 1));
    send_quat(make_quat(-1, 1, -1, 1));
    send_quat(make_quat(32767, 32767, 32767, 32767));
    send_quat(make_quat(-32768, -32768, -32768, -32768));
    send_quat(make_quat(-32768, 32767, -32768, 32767));
    send_quat(make_quat(11585, 11585, 0, 0));
    send_quat(make_quat(8192, 8192, 8192, 8192));
    send_quat(make_quat(0, 1, 2, 0));
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(-32768, 0, 0, 0));
    send_quat(make_quat(1, 2, 3, 4));
    send_quat(make_quat(32767, -32768, 1, -1));
  endtask

  task automatic test_random(int count);
    repeat (count) send_quat(make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
  endtask

  // Hold the receiver off long enough to fill the pipeline and stall the input
  task automatic test_backpressure();
    @(negedge clk_i);
    pressure_req = 1'b1;
    test_random(100);
  endtask

  // Steady full rate with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random(350);
  endtask

  // Receiver: random stall bursts and the long hold-off
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (pressure_req) begin
      pressure_req = 1'b0;
      stall_left = PRESSURE_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result with the oldest expected matrix
  always @(posedge clk_i) begin
    rot_t exp_m;
    bit bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (matrix_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        exp_m = matrix_q.pop_front();
        bad = (exp_m.zero_norm !== out_data_o.zero_norm);
        for (int k = 0; k < NUM_ENT; k++)
          if (exp_m[144-16*k -: 16] !== out_data_o[144-16*k -: 16]) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h got %h", exp_m, out_data_o);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(700);
    test_backpressure();
    test_random(680);
    test_full_rate();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && matrix_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
